/* rtl/u8dec_pkg.sv */
package u8dec_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [20:0] REPL_CHAR    = 21'h00fffd;
    localparam logic [20:0] MAX_SCALAR   = 21'h10ffff;
    localparam logic [20:0] SURR_LOW     = 21'h00d800;
    localparam logic [20:0] SURR_HIGH    = 21'h00dfff;
    localparam logic [20:0] TRAIL_BASE   = 21'h00dc00;
    localparam logic [20:0] SUPP_BASE    = 21'h010000;
    localparam logic [20:0] FLOOR_TWO    = 21'h000080;
    localparam logic [20:0] FLOOR_THREE  = 21'h000800;
    localparam logic [7:0]  CONT_MASK    = 8'h3f;

    // Minimum value class of an open sequence
    localparam logic [1:0] FLOOR_CLS_2B = 2'd0;
    localparam logic [1:0] FLOOR_CLS_3B = 2'd1;
    localparam logic [1:0] FLOOR_CLS_4B = 2'd2;

    // One decoded byte: rep_cnt replacements, then an optional scalar
    typedef struct packed {
        logic [2:0]  rep_cnt;
        logic        has_val;
        logic [20:0] value;
        logic        eot;
    } t_job;

endpackage

/* rtl/u8dec_front.sv */
module u8dec_front
    import u8dec_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_eot,
    output logic       o_push,
    output t_job       o_job
);

    logic [1:0]  r_need, n_need;
    logic [1:0]  r_taken, n_taken;
    logic [20:0] r_pv, n_pv;
    logic [1:0]  r_floor, n_floor;

    logic        is_cont;
    logic        do_lead;
    logic [20:0] v;
    logic [1:0]  tk;
    logic [20:0] flo;
    logic        bad;
    t_job        job;

    assign is_cont = (i_byte[7:6] == 2'b10);

    always_comb begin
        case (r_floor)
            FLOOR_CLS_2B: flo = FLOOR_TWO;
            FLOOR_CLS_3B: flo = FLOOR_THREE;
            default:      flo = SUPP_BASE;
        endcase
    end

    always_comb begin
        job     = '0;
        n_need  = r_need;
        n_taken = r_taken;
        n_pv    = r_pv;
        n_floor = r_floor;
        do_lead = 1'b1;
        v       = {r_pv[14:0], i_byte[5:0] & CONT_MASK[5:0]};
        tk      = r_taken + 2'd1;
        bad     = (v < flo) || (v > MAX_SCALAR) || ((v >= SURR_LOW) && (v <= SURR_HIGH));

        if (r_need != 2'd0) begin
            if (is_cont) begin
                do_lead = 1'b0;
                n_pv    = v;
                n_taken = tk;
                if (tk >= r_need) begin
                    if (bad) begin
                        job.rep_cnt = 3'd1;
                    end else begin
                        job.has_val = 1'b1;
                        job.value   = v;
                    end
                    n_need  = 2'd0;
                    n_taken = 2'd0;
                    n_pv    = '0;
                    n_floor = FLOOR_CLS_2B;
                end
            end else begin
                // one replacement for the lead and each continuation taken
                job.rep_cnt = {1'b0, r_taken} + 3'd1;
                n_need  = 2'd0;
                n_taken = 2'd0;
                n_pv    = '0;
                n_floor = FLOOR_CLS_2B;
            end
        end

        if (do_lead) begin
            if (i_byte[7] == 1'b0) begin
                job.has_val = 1'b1;
                job.value   = {13'd0, i_byte};
            end else if (i_byte[7:5] == 3'b110) begin
                n_need  = 2'd1;
                n_pv    = {16'd0, i_byte[4:0]};
                n_floor = FLOOR_CLS_2B;
            end else if (i_byte[7:4] == 4'b1110) begin
                n_need  = 2'd2;
                n_pv    = {17'd0, i_byte[3:0]};
                n_floor = FLOOR_CLS_3B;
            end else if (i_byte[7:3] == 5'b11110) begin
                n_need  = 2'd3;
                n_pv    = {18'd0, i_byte[2:0]};
                n_floor = FLOOR_CLS_4B;
            end else begin
                job.rep_cnt = job.rep_cnt + 3'd1;
            end
        end

        if (i_eot) begin
            // flush a truncated sequence at end of text
            if (n_need != 2'd0) begin
                job.rep_cnt = job.rep_cnt + {1'b0, n_taken} + 3'd1;
            end
            n_need  = 2'd0;
            n_taken = 2'd0;
            n_pv    = '0;
            n_floor = FLOOR_CLS_2B;
        end
        job.eot = i_eot;
    end

    assign o_job  = job;
    assign o_push = i_accept && ((job.rep_cnt != 3'd0) || job.has_val);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_need  <= 2'd0;
            r_taken <= 2'd0;
            r_pv    <= '0;
            r_floor <= FLOOR_CLS_2B;
        end else if (i_accept) begin
            r_need  <= n_need;
            r_taken <= n_taken;
            r_pv    <= n_pv;
            r_floor <= n_floor;
        end
    end

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_need == 2'd0) |-> (r_taken == 2'd0))
        else $error("taken count set with no open sequence");

    a_taken_below_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_need != 2'd0) |-> (r_taken < r_need))
        else $error("open sequence already complete");

    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_eot) |=> (r_need == 2'd0))
        else $error("sequence left open after end of text");

    a_eot_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_eot) |-> o_push)
        else $error("end of text produced no transaction");

endmodule

/* rtl/u8dec_queue.sv */
module u8dec_queue
    import u8dec_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count out of range");

endmodule

/* rtl/u8dec_back.sv */
module u8dec_back
    import u8dec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_mode16,
    input  logic        i_empty,
    input  t_job        i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [20:0] o_code,
    output logic        o_rep,
    output logic        o_last,
    output logic        o_done
);

    logic [1:0]  r_idx;
    logic        r_out_valid;
    logic [20:0] r_out_code;
    logic        r_out_rep;
    logic        r_out_last;
    logic        r_out_done;

    logic        adv;
    logic        emit;
    logic        split;
    logic [2:0]  total;
    logic [2:0]  idx_ext;
    logic [20:0] off;
    logic [20:0] hi_unit;
    logic [20:0] lo_unit;
    logic [20:0] unit;
    logic        unit_rep;
    logic        unit_last;

    assign adv     = !r_out_valid || i_ready;
    assign emit    = adv && !i_empty;
    assign split   = i_mode16 && i_head.has_val && (i_head.value[20:16] != 5'd0);
    assign total   = i_head.rep_cnt + {2'd0, i_head.has_val} + {2'd0, split};
    assign idx_ext = {1'b0, r_idx};
    assign off     = i_head.value - SUPP_BASE;
    assign hi_unit = SURR_LOW + {11'd0, off[19:10]};
    assign lo_unit = TRAIL_BASE + {11'd0, off[9:0]};

    always_comb begin
        unit_rep = 1'b0;
        if (idx_ext < i_head.rep_cnt) begin
            unit     = REPL_CHAR;
            unit_rep = 1'b1;
        end else if (split && (idx_ext == i_head.rep_cnt)) begin
            unit = hi_unit;
        end else if (split) begin
            unit = lo_unit;
        end else begin
            unit = i_head.value;
        end
    end

    assign unit_last = (idx_ext == total - 3'd1);
    assign o_pop     = emit && unit_last;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_code <= unit;
            r_out_rep  <= unit_rep;
            r_out_last <= unit_last;
            r_out_done <= unit_last && i_head.eot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= !i_empty;
            end
            // advance through the units of the head transaction
            if (emit) begin
                r_idx <= unit_last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_code  = r_out_code;
    assign o_rep   = r_out_rep;
    assign o_last  = r_out_last;
    assign o_done  = r_out_done;

    a_idx_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_idx == 2'd0))
        else $error("unit index not cleared after pop");

    a_rep_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_rep) |-> (r_out_code == REPL_CHAR))
        else $error("replacement flag on a non-replacement unit");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done) |-> r_out_last)
        else $error("text end not on last unit of its byte");

    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (idx_ext < total))
        else $error("unit index beyond transaction length");

endmodule

/* rtl/utf8_to_code_unit_decoder_core.sv */
// UTF-8 to code unit decoder.
// Input stream: one byte of UTF-8 text per transaction in s_axis_tdata[7:0], with
// s_axis_tlast on the final byte of a text. Output stream: one code unit per
// transaction in m_axis_tdata[20:0]; m_axis_tlast marks the final unit caused by
// an input byte, m_axis_tuser[0] flags a U+FFFD produced for malformed input and
// m_axis_tuser[1] marks the final unit of the whole text.
// i_cfg_we / i_cfg_wdata select 16-bit units with surrogate pairs (1, the reset
// value) or unsplit 21-bit scalars (0); write it only while the block is idle.
// An accepted byte goes to the job queue between decoder and unit sequencer, then
// its units pass through the output register. The block takes one byte per cycle
// and emits one code unit per cycle while m_axis_tready is high; a byte yields up
// to four units, sent one by one; s_axis_tready drops only when the queue is full.
// A byte that merely opens or extends a sequence yields no unit.
// Reset clears the decoder state, the queue and the output valid flag and restores
// 16-bit mode. When m_axis_tready is low the output register holds its unit, the
// queue fills behind it and then input is stalled; nothing is dropped.
module utf8_to_code_unit_decoder_core
    import u8dec_pkg::*;
#(
    parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_unit, [23:21] zero
    output logic [1:0]  m_axis_tuser,   // [0] is_replacement, [1] text_done
    output logic        m_axis_tlast    // last_of_run
);

    logic        r_unit_width_mode;
    logic        accept;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    t_job        front_job;
    t_job        head_job;
    logic [20:0] code;
    logic        rep;
    logic        done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_width_mode <= 1'b1;
        end else if (i_cfg_we) begin
            r_unit_width_mode <= i_cfg_wdata;
        end
    end

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    u8dec_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_eot    (s_axis_tlast),
        .o_push   (push),
        .o_job    (front_job)
    );

    u8dec_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_job)
    );

    u8dec_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_mode16 (r_unit_width_mode),
        .i_empty  (q_empty),
        .i_head   (head_job),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_code   (code),
        .o_rep    (rep),
        .o_last   (m_axis_tlast),
        .o_done   (done)
    );

    assign m_axis_tdata = {3'b000, code};
    assign m_axis_tuser = {done, rep};

endmodule

/* sim/utf8_to_code_unit_decoder_core_tb.sv */
`timescale 1ns / 1ps

module utf8_to_code_unit_decoder_core_tb;
    import u8dec_pkg::*;

    localparam logic [20:0] BMP_MAX        = 21'h00ffff;
    localparam logic [20:0] SURR_MASK      = 21'h0003ff;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          SETTLE_CYCLES  = 10;
    localparam int          DRAIN_CYCLES   = 20;

    typedef struct packed {
        logic [20:0] unit;
        logic        repl;
        logic        last;
        logic        done;
    } t_code_unit;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       eot;
    } t_text_item;

    // Decodes accepted bytes into expected code units and checks the output stream
    class utf8_unit_checker;
        bit         wide_mode;
        bit [1:0]   need_cnt;
        bit [1:0]   taken_cnt;
        bit [1:0]   floor_cls;
        bit [20:0]  partial;
        t_code_unit run_units[$];
        t_code_unit expected_units[$];
        int         error_count;

        function new();
            wide_mode   = 1'b1;
            error_count = 0;
            clear_seq();
        endfunction

        function void clear_seq();
            need_cnt  = 2'd0;
            taken_cnt = 2'd0;
            floor_cls = FLOOR_CLS_2B;
            partial   = '0;
        endfunction

        function void set_mode(bit m);
            wide_mode = m;
        endfunction

        function int pending();
            return expected_units.size();
        endfunction

        function void add_unit(bit [20:0] u, bit r);
            t_code_unit cu;
            cu.unit = u;
            cu.repl = r;
            cu.last = 1'b0;
            cu.done = 1'b0;
            run_units.push_back(cu);
        endfunction

        function void add_replacements(int count);
            repeat (count) add_unit(REPL_CHAR, 1'b1);
        endfunction

        function void take_lead(bit [7:0] b);
            if (b[7] == 1'b0) begin
                add_unit({13'd0, b}, 1'b0);
            end else if (b[7:5] == 3'b110) begin
                need_cnt  = 2'd1;
                partial   = {16'd0, b[4:0]};
                floor_cls = FLOOR_CLS_2B;
            end else if (b[7:4] == 4'b1110) begin
                need_cnt  = 2'd2;
                partial   = {17'd0, b[3:0]};
                floor_cls = FLOOR_CLS_3B;
            end else if (b[7:3] == 5'b11110) begin
                need_cnt  = 2'd3;
                partial   = {18'd0, b[2:0]};
                floor_cls = FLOOR_CLS_4B;
            end else begin
                add_unit(REPL_CHAR, 1'b1);
            end
        endfunction

        function void finish_seq();
            bit [20:0] min_val;
            bit [20:0] off;
            min_val = (floor_cls == FLOOR_CLS_2B) ? FLOOR_TWO :
                      (floor_cls == FLOOR_CLS_3B) ? FLOOR_THREE : SUPP_BASE;
            if (partial < min_val || partial > MAX_SCALAR ||
                (partial >= SURR_LOW && partial <= SURR_HIGH)) begin
                add_unit(REPL_CHAR, 1'b1);
            end else if (wide_mode && partial > BMP_MAX) begin
                off = partial - SUPP_BASE;
                add_unit(SURR_LOW + (off >> 10), 1'b0);
                add_unit(TRAIL_BASE + (off & SURR_MASK), 1'b0);
            end else begin
                add_unit(partial, 1'b0);
            end
            clear_seq();
        endfunction

        function void note_byte(bit [7:0] b, bit eot);
            t_code_unit cu;
            run_units.delete();
            if (need_cnt != 2'd0) begin
                if (b[7:6] == 2'b10) begin
                    partial   = {partial[14:0], b[5:0]};
                    taken_cnt = taken_cnt + 2'd1;
                    if (taken_cnt >= need_cnt)
                        finish_seq();
                end else begin
                    // replace lead and taken continuations, then restart on this byte
                    add_replacements(1 + taken_cnt);
                    clear_seq();
                    take_lead(b);
                end
            end else begin
                take_lead(b);
            end
            if (eot) begin
                if (need_cnt != 2'd0)
                    add_replacements(1 + taken_cnt);
                clear_seq();
            end
            if (run_units.size() > 0) begin
                cu = run_units.pop_back();
                cu.last = 1'b1;
                cu.done = eot;
                run_units.push_back(cu);
            end
            foreach (run_units[i])
                expected_units.push_back(run_units[i]);
        endfunction

        task report(string msg);
            $display("%0t: mismatch: %s", $realtime, msg);
            error_count++;
        endtask

        task check_unit(input logic [20:0] u, input logic r, input logic l, input logic d);
            t_code_unit want;
            if (expected_units.size() == 0) begin
                report($sformatf("unexpected unit %h repl %b last %b done %b", u, r, l, d));
            end else begin
                want = expected_units.pop_front();
                if (u !== want.unit || r !== want.repl || l !== want.last || d !== want.done)
                    report($sformatf("unit %h repl %b last %b done %b, want %h %b %b %b",
                                     u, r, l, d, want.unit, want.repl, want.last, want.done));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] text_byte
    logic        s_axis_tlast;   // end_of_text
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [20:0] code_unit, [23:21] zero
    logic [1:0]  m_axis_tuser;   // [0] is_replacement, [1] text_done
    logic        m_axis_tlast;   // last_of_run

    utf8_unit_checker sb;
    t_text_item       text_items[$];
    logic [8:0]       directed_text[$];
    bit               hold_req;
    int               idle_cycles;

    utf8_to_code_unit_decoder_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function void push_byte(bit [7:0] b, bit eot);
        t_text_item it;
        it.text_byte = b;
        it.eot       = eot;
        text_items.push_back(it);
    endfunction

    function void push_random_byte(bit [7:0] b);
        push_byte(b, $urandom_range(0, 29) == 0);
    endfunction

    function bit [7:0] random_lead(int conts);
        case (conts)
            1:       return {3'b110, 5'($urandom_range(0, 31))};
            2:       return {4'b1110, 4'($urandom_range(0, 15))};
            default: return {5'b11110, 3'($urandom_range(0, 4))};
        endcase
    endfunction

    // Mostly well-formed sequences with random content; some noise and truncation
    task automatic build_random_text(input int count);
        int kind;
        int conts;
        int taken;
        text_items.delete();
        while (text_items.size() < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
                push_random_byte(8'($urandom_range(0, 127)));
            end else if (kind < 82) begin
                conts = $urandom_range(1, 3);
                push_random_byte(random_lead(conts));
                repeat (conts) push_random_byte({2'b10, 6'($urandom_range(0, 63))});
            end else if (kind < 92) begin
                push_random_byte(8'($urandom_range(0, 255)));
            end else begin
                conts = $urandom_range(1, 3);
                taken = $urandom_range(0, conts - 1);
                push_random_byte(random_lead(conts));
                repeat (taken) push_random_byte({2'b10, 6'($urandom_range(0, 63))});
            end
        end
    endtask

    task automatic send_text();
        int burst;
        int gap;
        burst = 0;
        foreach (text_items[i]) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                if (gap != 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= text_items[i].text_byte;
            s_axis_tlast  <= text_items[i].eot;
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            burst--;
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_unit_mode(input bit m);
        wait_drained();
        // a byte that only opens a sequence may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_mode(m);
    endtask

    // Receiver stall pattern; a long hold-off when requested
    initial begin
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        m_axis_tready <= 1'b1;
                        repeat ($urandom_range(8, 60)) @(posedge i_clk);
                    end
                    1: repeat (30) begin
                        m_axis_tready <= 1'($urandom_range(0, 1));
                        @(posedge i_clk);
                    end
                    2: begin
                        m_axis_tready <= 1'b0;
                        repeat ($urandom_range(1, 6)) @(posedge i_clk);
                        m_axis_tready <= 1'b1;
                        @(posedge i_clk);
                    end
                    default: repeat (8) begin
                        m_axis_tready <= ~m_axis_tready;
                        @(posedge i_clk);
                    end
                endcase
            end
        end
    end

    // Record accepted bytes before checking units of the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_unit(m_axis_tdata[20:0], m_axis_tuser[0], m_axis_tlast,
                              m_axis_tuser[1]);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog: no transaction for %0d cycles", $realtime,
                         idle_cycles);
                $display("utf8_to_code_unit_decoder_core_tb: errors");
                $finish;
            end
        end
    end

    initial begin
        sb            = new();
        hold_req      = 1'b0;
        idle_cycles   = 0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        // bit 8 marks end of text
        directed_text = '{
            9'h000, 9'h07f,
            9'h0f0, 9'h09f, 9'h098, 9'h080,   // supplementary: surrogate pair
            9'h0ef, 9'h0bf, 9'h1bd,           // literal U+FFFD completed at end of text
            9'h080, 9'h0ff,                   // invalid leads
            9'h0c0, 9'h080,                   // overlong
            9'h0ed, 9'h0a0, 9'h080,           // encoded surrogate
            9'h0f4, 9'h090, 9'h080, 9'h080,   // above max scalar
            9'h0f0, 9'h09f, 9'h098, 9'h141,   // bad continuation on final byte
            9'h0e2, 9'h182                    // truncated at end of text
        };
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_unit_mode(1'b1);
        text_items.delete();
        foreach (directed_text[i])
            push_byte(directed_text[i][7:0], directed_text[i][8]);
        send_text();

        write_unit_mode(1'b0);
        build_random_text(130);
        send_text();

        write_unit_mode(1'b1);
        build_random_text(130);
        hold_req = 1'b1;
        wait (hold_req == 1'b0);
        send_text();

        write_unit_mode(1'b0);
        build_random_text(140);
        send_text();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("utf8_to_code_unit_decoder_core_tb: clean");
        else
            $display("utf8_to_code_unit_decoder_core_tb: errors");
        $finish;
    end

endmodule

/* utf8_to_code_unit_decoder_core.f */
rtl/u8dec_pkg.sv
rtl/u8dec_front.sv
rtl/u8dec_queue.sv
rtl/u8dec_back.sv
rtl/utf8_to_code_unit_decoder_core.sv
sim/utf8_to_code_unit_decoder_core_tb.sv
